// File: hdl/mus_event_parser_unit_macros.svh
// Assertion helpers for the MUS event parser.
// MEP_ASSERT checks a property on the rising clock edge and skips it while reset is high.
// MEP_ASSERT_ALWAYS checks a property on every rising clock edge, reset included.
`ifndef MUS_EVENT_PARSER_UNIT_MACROS_SVH
`define MUS_EVENT_PARSER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MEP_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);
`define MEP_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define MEP_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define MEP_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)
`endif
`endif

// File: hdl/mep_pkg.sv
package mep_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int CH_W          = 4;

  localparam logic [6:0] VEL_DEFAULT = 7'd127;
  localparam logic [7:0] SYS_OFF_A   = 8'd10;
  localparam logic [7:0] SYS_OFF_B   = 8'd11;

  typedef logic [31:0] delay_t;

  // Result codes on the output stream.
  typedef enum logic [2:0] {
    EV_RELEASE    = 3'd0,
    EV_PLAY       = 3'd1,
    EV_WHEEL      = 3'd2,
    EV_ALL_OFF    = 3'd3,
    EV_CONTROLLER = 3'd4,
    EV_DELAY      = 3'd5,
    EV_STOP       = 3'd6,
    EV_RESTART    = 3'd7
  } ev_code_t;

  // Event types in a score header byte.
  typedef enum logic [2:0] {
    MT_RELEASE    = 3'd0,
    MT_PLAY       = 3'd1,
    MT_WHEEL      = 3'd2,
    MT_SYSTEM     = 3'd3,
    MT_CONTROLLER = 3'd4,
    MT_MEASURE    = 3'd5,
    MT_SCORE_END  = 3'd6,
    MT_SPARE      = 3'd7
  } msg_type_t;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA1  = 4'b0010,
    PH_DATA2  = 4'b0100,
    PH_DELAY  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    RUN_STOPPED = 3'b001,
    RUN_PLAYING = 3'b010,
    RUN_DISCARD = 3'b100
  } run_t;

  typedef struct packed {
    ev_code_t          code;
    logic [CH_W-1:0]   channel;
    logic [7:0]        key;
    logic [7:0]        level;
    delay_t            delay;
  } result_t;

  // One queue entry: all results caused by one input beat.
  // The second result is always a stop or a restart.
  typedef struct packed {
    result_t first;
    logic    has_second;
    logic    restart;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: hdl/mep_front.sv
module mep_front #(
  parameter int DELAY_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_loop,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  mep_pkg::q_status_t  q_stat,
  output logic                q_push,
  output mep_pkg::q_entry_t   q_data
);

  logic                          loop_enable;
  mep_pkg::phase_t               phase, phase_next;
  mep_pkg::msg_type_t            event_type, event_type_next;
  logic [mep_pkg::CH_W-1:0]      event_channel, event_channel_next;
  logic [7:0]                    first_data, first_data_next;
  logic                          delay_follows, delay_follows_next;
  logic [DELAY_WIDTH-1:0]        delay_sum, delay_sum_next;
  logic [6:0]                    vel [mep_pkg::CHANNEL_COUNT];
  logic [6:0]                    vel_next [mep_pkg::CHANNEL_COUNT];
  mep_pkg::run_t                 run_mode, run_mode_next;

  logic              accept;
  logic              has_first;
  logic              end_now;
  logic              score_end;
  logic              clear_parser;
  mep_pkg::result_t  first_res;
  mep_pkg::result_t  end_res;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_next         = phase;
    event_type_next    = event_type;
    event_channel_next = event_channel;
    first_data_next    = first_data;
    delay_follows_next = delay_follows;
    delay_sum_next     = delay_sum;
    vel_next           = vel;
    run_mode_next      = run_mode;
    has_first          = 1'b0;
    score_end          = 1'b0;
    end_now            = 1'b0;
    clear_parser       = 1'b0;
    first_res          = '0;
    first_res.channel  = event_channel;
    end_res            = '0;
    end_res.code       = mep_pkg::EV_STOP;

    if (in_kind) begin
      clear_parser  = 1'b1;
      run_mode_next = mep_pkg::RUN_PLAYING;
    end else if (run_mode == mep_pkg::RUN_DISCARD) begin
      if (in_last) begin
        run_mode_next = mep_pkg::RUN_PLAYING;
      end
    end else if (run_mode == mep_pkg::RUN_PLAYING) begin
      case (phase)
        mep_pkg::PH_HEADER: begin
          event_type_next    = mep_pkg::msg_type_t'(in_byte[6:4]);
          event_channel_next = in_byte[3:0];
          delay_follows_next = in_byte[7];
          if (in_byte[6:4] == mep_pkg::MT_SCORE_END) begin
            score_end = 1'b1;
          end else if (in_byte[6:4] == mep_pkg::MT_MEASURE) begin
            phase_next = in_byte[7] ? mep_pkg::PH_DELAY : mep_pkg::PH_HEADER;
            if (in_byte[7]) begin
              delay_sum_next = '0;
            end
          end else begin
            phase_next = mep_pkg::PH_DATA1;
          end
        end
        mep_pkg::PH_DATA1: begin
          phase_next = delay_follows ? mep_pkg::PH_DELAY : mep_pkg::PH_HEADER;
          if (delay_follows) begin
            delay_sum_next = '0;
          end
          case (event_type)
            mep_pkg::MT_RELEASE: begin
              has_first     = 1'b1;
              first_res.code = mep_pkg::EV_RELEASE;
              first_res.key  = {1'b0, in_byte[6:0]};
            end
            mep_pkg::MT_PLAY: begin
              if (in_byte[7]) begin
                // Volume byte follows; hold the note.
                first_data_next = in_byte;
                phase_next      = mep_pkg::PH_DATA2;
                delay_sum_next  = delay_sum;
              end else begin
                has_first       = 1'b1;
                first_res.code  = mep_pkg::EV_PLAY;
                first_res.key   = in_byte;
                first_res.level = {1'b0, vel[event_channel]};
              end
            end
            mep_pkg::MT_WHEEL: begin
              has_first       = 1'b1;
              first_res.code  = mep_pkg::EV_WHEEL;
              first_res.level = in_byte;
            end
            mep_pkg::MT_SYSTEM: begin
              if (in_byte == mep_pkg::SYS_OFF_A || in_byte == mep_pkg::SYS_OFF_B) begin
                has_first      = 1'b1;
                first_res.code = mep_pkg::EV_ALL_OFF;
              end
            end
            mep_pkg::MT_CONTROLLER: begin
              first_data_next = in_byte;
              phase_next      = mep_pkg::PH_DATA2;
              delay_sum_next  = delay_sum;
            end
            default: begin
            end
          endcase
        end
        mep_pkg::PH_DATA2: begin
          phase_next = delay_follows ? mep_pkg::PH_DELAY : mep_pkg::PH_HEADER;
          if (delay_follows) begin
            delay_sum_next = '0;
          end
          if (event_type == mep_pkg::MT_PLAY) begin
            vel_next[event_channel] = in_byte[6:0];
            has_first       = 1'b1;
            first_res.code  = mep_pkg::EV_PLAY;
            first_res.key   = {1'b0, first_data[6:0]};
            first_res.level = {1'b0, in_byte[6:0]};
          end else if (event_type == mep_pkg::MT_CONTROLLER) begin
            has_first       = 1'b1;
            first_res.code  = mep_pkg::EV_CONTROLLER;
            first_res.key   = first_data;
            first_res.level = in_byte;
          end
        end
        mep_pkg::PH_DELAY: begin
          delay_sum_next = {delay_sum[DELAY_WIDTH-8:0], in_byte[6:0]};
          if (!in_byte[7]) begin
            phase_next = mep_pkg::PH_HEADER;
            if (delay_sum_next != '0) begin
              has_first         = 1'b1;
              first_res.code    = mep_pkg::EV_DELAY;
              first_res.channel = '0;
              first_res.delay   = mep_pkg::delay_t'(delay_sum_next);
            end
          end
        end
        default: begin
          phase_next = mep_pkg::PH_HEADER;
        end
      endcase

      end_now = score_end || in_last;
      if (end_now) begin
        if (loop_enable) begin
          end_res.code  = mep_pkg::EV_RESTART;
          end_res.delay = mep_pkg::delay_t'(1);
          clear_parser  = 1'b1;
          run_mode_next = in_last ? mep_pkg::RUN_PLAYING : mep_pkg::RUN_DISCARD;
        end else begin
          run_mode_next = mep_pkg::RUN_STOPPED;
        end
      end
    end

    if (clear_parser) begin
      phase_next         = mep_pkg::PH_HEADER;
      event_type_next    = mep_pkg::MT_RELEASE;
      event_channel_next = '0;
      first_data_next    = '0;
      delay_follows_next = 1'b0;
      delay_sum_next     = '0;
      for (int i = 0; i < mep_pkg::CHANNEL_COUNT; i++) begin
        vel_next[i] = mep_pkg::VEL_DEFAULT;
      end
    end
  end

  always_comb begin
    q_push            = accept && (has_first || end_now);
    q_data.first      = has_first ? first_res : end_res;
    q_data.has_second = has_first && end_now;
    q_data.restart    = (end_res.code == mep_pkg::EV_RESTART);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable   <= 1'b0;
      phase         <= mep_pkg::PH_HEADER;
      event_type    <= mep_pkg::MT_RELEASE;
      event_channel <= '0;
      first_data    <= '0;
      delay_follows <= 1'b0;
      delay_sum     <= '0;
      run_mode      <= mep_pkg::RUN_STOPPED;
      for (int i = 0; i < mep_pkg::CHANNEL_COUNT; i++) begin
        vel[i] <= mep_pkg::VEL_DEFAULT;
      end
    end else begin
      if (cfg_we) begin
        loop_enable <= cfg_loop;
      end
      if (accept) begin
        phase         <= phase_next;
        event_type    <= event_type_next;
        event_channel <= event_channel_next;
        first_data    <= first_data_next;
        delay_follows <= delay_follows_next;
        delay_sum     <= delay_sum_next;
        run_mode      <= run_mode_next;
        vel           <= vel_next;
      end
    end
  end

endmodule

// File: hdl/mep_queue.sv
`include "mus_event_parser_unit_macros.svh"

module mep_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mep_pkg::q_entry_t  push_data,
  input  logic               pop,
  output mep_pkg::q_entry_t  pop_data,
  output mep_pkg::q_status_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mep_pkg::q_entry_t  mem [DEPTH];
  mep_pkg::q_entry_t  head;
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   rd_ptr_inc;
  logic [CNT_W-1:0]   count;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign pop_data   = head;
  assign rd_ptr_inc = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  // Hold the oldest entry in a register. Take the incoming entry directly
  // when the queue is empty or about to run dry, else read the next slot.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (push && (count == '0 || (pop && count == CNT_W'(1)))) begin
      head <= push_data;
    end else if (pop) begin
      head <= mem[rd_ptr_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_inc;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `MEP_ASSERT(a_no_push_full, clk, rst, !(push && stat.full), "push into a full queue")
  `MEP_ASSERT(a_no_pop_empty, clk, rst, !(pop && stat.empty), "pop from an empty queue")
  `MEP_ASSERT(a_count_step, clk, rst, (push && !pop && !stat.full) |=> !stat.empty, "push lost")

endmodule

// File: hdl/mep_back.sv
`include "mus_event_parser_unit_macros.svh"

module mep_back (
  input  logic               clk,
  input  logic               rst,
  input  mep_pkg::q_status_t q_stat,
  input  mep_pkg::q_entry_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output mep_pkg::result_t   out_res,
  output logic               out_last
);

  mep_pkg::q_entry_t cur;
  logic              cur_valid;
  logic              second;
  logic              take;
  logic              more;
  logic              free;
  mep_pkg::result_t  end_res;

  assign take  = out_valid && out_ready;
  assign more  = cur.has_second && !second;
  assign free  = !cur_valid || (take && !more);
  assign q_pop = free && !q_stat.empty;

  always_comb begin
    end_res       = '0;
    end_res.code  = cur.restart ? mep_pkg::EV_RESTART : mep_pkg::EV_STOP;
    end_res.delay = cur.restart ? mep_pkg::delay_t'(1) : '0;
  end

  assign out_valid = cur_valid;
  assign out_res   = second ? end_res : cur.first;
  assign out_last  = second || !cur.has_second;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      second    <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      second    <= 1'b0;
    end else if (free) begin
      cur_valid <= 1'b0;
      second    <= 1'b0;
    end else if (take && more) begin
      second <= 1'b1;
    end
  end

  `MEP_ASSERT(a_second_exists, clk, rst, second |-> (cur_valid && cur.has_second), "bad second slot")
  `MEP_ASSERT(a_second_is_end, clk, rst,
              (out_valid && second) |->
              (out_res.code == mep_pkg::EV_STOP || out_res.code == mep_pkg::EV_RESTART),
              "second result is not an end event")
  `MEP_ASSERT(a_end_is_last, clk, rst,
              (out_valid && (out_res.code == mep_pkg::EV_STOP ||
                             out_res.code == mep_pkg::EV_RESTART)) |-> out_last,
              "end event not marked last")

endmodule

// File: hdl/mus_event_parser_unit.sv
// Channel  Dir  Beat carries
// s_axis   in   tuser kind, tdata score byte, tlast score_last
// m_axis   out  tuser event code, tdata channel/key/level/delay, tlast last_of_run
// cfg      in   cfg_data loop_enable (restart at score end instead of stop)
//
// Cycles: one input beat per clock; the parser state updates in the accepting cycle.
// A result passes the queue head register and then the back holding register to m_axis.
// Output: one result per clock; a beat that gives two results (delay or event plus
// stop/restart) holds the output port for both of them, absorbed by the result queue.
// Stalls: s_tready drops only when the result queue is full; m_tready low backs up
// into the queue first. Reset: synchronous, stopped until a start beat (kind = 1).
module mus_event_parser_unit #(
  parameter int DELAY_WIDTH = 32, // width of the delay accumulator, 16 to 32
  parameter int QUEUE_DEPTH = 4   // result queue entries, 2 or more
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,   // [0] loop_enable
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] byte_value
  input  logic        s_tuser,    // [0] kind
  input  logic        s_tlast,    // score_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,    // [3:0] channel, [11:4] key, [19:12] level,
                                  // [51:20] delay_ticks, [55:52] zero
  output logic [2:0]  m_tuser,    // [2:0] event_code
  output logic        m_tlast     // last_of_run
);

  mep_pkg::q_status_t q_stat;
  mep_pkg::q_entry_t  q_in;
  mep_pkg::q_entry_t  q_out;
  logic               q_push;
  logic               q_pop;
  mep_pkg::result_t   res;

  // The register write is always accepted; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  // Front: parse each accepted beat and push its results as one entry.
  mep_front #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_loop (cfg_data),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // Queue: decouple parsing from result delivery.
  mep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  // Back: hold an entry and hand out its one or two results.
  mep_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res),
    .out_last  (m_tlast)
  );

  assign m_tuser = res.code;
  assign m_tdata = {4'b0000, res.delay, res.level, res.key, res.channel};

endmodule
